/* hdl/vbif_pkg.sv */
package vbif_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int COEFF_BITS = 16;

   localparam int SAMPLE_W = 16;
   localparam int COEFF_W  = 16;
   localparam int STATE_W  = 32;

   // three-term sums of state values, product with a zero-extended coefficient
   localparam int OP_W   = STATE_W + 2;
   localparam int PROD_W = OP_W + COEFF_W + 1;
   localparam int RES_W  = PROD_W - COEFF_BITS;
   localparam int ACC_W  = (RES_W > STATE_W) ? RES_W + 1 : STATE_W + 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HP_COEFF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LP_COEFF = 2'd2;

   localparam logic [COEFF_W-1:0] HP_COEFF_RESET = 16'd49869;
   localparam logic [COEFF_W-1:0] LP_COEFF_RESET = 16'd42820;

endpackage

/* hdl/voice_band_iir_filter.sv */
// Channel | Ports                                     | Direction
// req     | req_valid, req_ready, req_sample_in       | sample in
// rsp     | rsp_valid, rsp_ready, rsp_sample_out      | sample out
// csr     | csr_write_en, csr_index, csr_write_data   | register write
//
// A filtered item passes through an accept step, an operand step, then a multiply and a
// store step for each of the four RC stages, all sharing one 34x17 multiplier, and a
// final step that loads the output register. A bypassed item goes from the accept step
// straight to that final step. req_ready is high only while the sequencer is idle;
// a held result in the output register stalls only the final step.
// Reset clears the filter state, the enable history and restores the coefficients.
module voice_band_iir_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [vbif_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [vbif_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                   csr_write_en,
   input  logic        [vbif_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [vbif_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int SampleW  = vbif_pkg::SAMPLE_W;
   localparam int StateW   = vbif_pkg::STATE_W;
   localparam int CoeffW   = vbif_pkg::COEFF_W;
   localparam int CoefBits = vbif_pkg::COEFF_BITS;
   localparam int FracBits = vbif_pkg::FRAC_BITS;
   localparam int OpW      = vbif_pkg::OP_W;
   localparam int ProdW    = vbif_pkg::PROD_W;
   localparam int ResW     = vbif_pkg::RES_W;
   localparam int AccW     = vbif_pkg::ACC_W;
   localparam int OutW     = StateW + 1;

   typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_MUL, ST_STORE, ST_OUT} state_type;
   typedef enum logic [1:0] {STG_HP1, STG_HP2, STG_LP1, STG_LP2} stage_type;

   function automatic logic signed [StateW-1:0] sat_state(input logic signed [AccW-1:0] v);
      logic signed [StateW-1:0] r;
      if (&v[AccW-1:StateW-1] || ~|v[AccW-1:StateW-1]) begin
         r = v[StateW-1:0];
      end else if (v[AccW-1]) begin
         r = {1'b1, {(StateW-1){1'b0}}};
      end else begin
         r = {1'b0, {(StateW-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [SampleW-1:0] sat_sample(input logic signed [OutW-1:0] v);
      logic signed [SampleW-1:0] r;
      if (&v[OutW-1:SampleW-1] || ~|v[OutW-1:SampleW-1]) begin
         r = v[SampleW-1:0];
      end else if (v[OutW-1]) begin
         r = {1'b1, {(SampleW-1){1'b0}}};
      end else begin
         r = {1'b0, {(SampleW-1){1'b1}}};
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   stage_type stage_ff, stage_in;

   logic                       enable_ff, enable_in;
   logic                       last_enable_ff, last_enable_in;
   logic        [CoeffW-1:0]   hp_coeff_ff, hp_coeff_in;
   logic        [CoeffW-1:0]   lp_coeff_ff, lp_coeff_in;

   logic signed [StateW-1:0]   prev_input_ff, prev_input_in;
   logic signed [StateW-1:0]   prev_high_one_ff, prev_high_one_in;
   logic signed [StateW-1:0]   high_one_ff, high_one_in;
   logic signed [StateW-1:0]   high_two_ff, high_two_in;
   logic signed [StateW-1:0]   low_one_ff, low_one_in;
   logic signed [StateW-1:0]   low_two_ff, low_two_in;

   logic signed [SampleW-1:0]  sample_ff, sample_in;
   logic                       bypass_ff, bypass_in;
   logic signed [OpW-1:0]      op_ff, op_in;
   logic signed [ProdW-1:0]    prod_ff, prod_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SampleW-1:0]  rsp_sample_ff, rsp_sample_in;

   logic signed [StateW-1:0]   x_val;
   logic signed [ResW-1:0]     res_val;
   logic signed [StateW-1:0]   stored_hp;
   logic signed [StateW-1:0]   sum_lp1;
   logic signed [StateW-1:0]   sum_lp2;
   logic signed [CoeffW:0]     coeff_sel;
   logic signed [OutW-1:0]     out_biased;
   logic signed [OutW-1:0]     out_shifted;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   always_comb begin
      x_val     = StateW'(sample_ff) <<< FracBits;
      res_val   = $signed(prod_ff[ProdW-1:CoefBits]);
      stored_hp = sat_state(AccW'(res_val));
      sum_lp1   = sat_state(AccW'(low_one_ff) + AccW'(res_val));
      sum_lp2   = sat_state(AccW'(low_two_ff) + AccW'(res_val));
      if (stage_ff == STG_HP1 || stage_ff == STG_HP2) begin
         coeff_sel = $signed({1'b0, hp_coeff_ff});
      end else begin
         coeff_sel = $signed({1'b0, lp_coeff_ff});
      end
      // truncate toward zero: bias negative values before the arithmetic shift
      out_biased = OutW'(low_two_ff);
      if (low_two_ff[StateW-1]) begin
         out_biased = out_biased + OutW'((1 << (FracBits - 1)) - 1);
      end
      out_shifted = out_biased >>> (FracBits - 1);
   end

   always_comb begin
      state_in         = state_ff;
      stage_in         = stage_ff;
      enable_in        = enable_ff;
      last_enable_in   = last_enable_ff;
      hp_coeff_in      = hp_coeff_ff;
      lp_coeff_in      = lp_coeff_ff;
      prev_input_in    = prev_input_ff;
      prev_high_one_in = prev_high_one_ff;
      high_one_in      = high_one_ff;
      high_two_in      = high_two_ff;
      low_one_in       = low_one_ff;
      low_two_in       = low_two_ff;
      sample_in        = sample_ff;
      bypass_in        = bypass_ff;
      op_in            = op_ff;
      prod_in          = prod_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_sample_in    = rsp_sample_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         case (csr_index)
            vbif_pkg::CSR_ENABLE:   enable_in   = csr_write_data[0];
            vbif_pkg::CSR_HP_COEFF: hp_coeff_in = csr_write_data[CoeffW-1:0];
            vbif_pkg::CSR_LP_COEFF: lp_coeff_in = csr_write_data[CoeffW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample_in;
               bypass_in = !enable_ff;
               // drop all filter history on a change of mode
               if (enable_ff != last_enable_ff) begin
                  last_enable_in   = enable_ff;
                  prev_input_in    = '0;
                  prev_high_one_in = '0;
                  high_one_in      = '0;
                  high_two_in      = '0;
                  low_one_in       = '0;
                  low_two_in       = '0;
               end
               state_in = enable_ff ? ST_LOAD : ST_OUT;
            end
         end
         ST_LOAD: begin
            op_in         = OpW'(high_one_ff) + OpW'(x_val) - OpW'(prev_input_ff);
            prev_input_in = x_val;
            stage_in      = STG_HP1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = ProdW'(op_ff) * ProdW'(coeff_sel);
            state_in = ST_STORE;
         end
         ST_STORE: begin
            // write back this stage and, except after the last stage, form the next stage's operand
            case (stage_ff)
               STG_HP1: begin
                  high_one_in      = stored_hp;
                  prev_high_one_in = stored_hp;
                  op_in    = OpW'(high_two_ff) + OpW'(stored_hp) - OpW'(prev_high_one_ff);
                  stage_in = STG_HP2;
                  state_in = ST_MUL;
               end
               STG_HP2: begin
                  high_two_in = stored_hp;
                  op_in       = OpW'(stored_hp) - OpW'(low_one_ff);
                  stage_in    = STG_LP1;
                  state_in    = ST_MUL;
               end
               STG_LP1: begin
                  low_one_in = sum_lp1;
                  op_in      = OpW'(sum_lp1) - OpW'(low_two_ff);
                  stage_in   = STG_LP2;
                  state_in   = ST_MUL;
               end
               STG_LP2: begin
                  low_two_in = sum_lp2;
                  state_in   = ST_OUT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = bypass_ff ? sample_ff : sat_sample(out_shifted);
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         stage_ff         <= STG_HP1;
         enable_ff        <= 1'b0;
         last_enable_ff   <= 1'b0;
         hp_coeff_ff      <= vbif_pkg::HP_COEFF_RESET;
         lp_coeff_ff      <= vbif_pkg::LP_COEFF_RESET;
         prev_input_ff    <= '0;
         prev_high_one_ff <= '0;
         high_one_ff      <= '0;
         high_two_ff      <= '0;
         low_one_ff       <= '0;
         low_two_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         stage_ff         <= stage_in;
         enable_ff        <= enable_in;
         last_enable_ff   <= last_enable_in;
         hp_coeff_ff      <= hp_coeff_in;
         lp_coeff_ff      <= lp_coeff_in;
         prev_input_ff    <= prev_input_in;
         prev_high_one_ff <= prev_high_one_in;
         high_one_ff      <= high_one_in;
         high_two_ff      <= high_two_in;
         low_one_ff       <= low_one_in;
         low_two_ff       <= low_two_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      bypass_ff     <= bypass_in;
      op_ff         <= op_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam logic [vbif_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam longint SAMPLE_MAX = (longint'(1) << (vbif_pkg::SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam int PHASE_ITEMS = 350;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type                          kind;
      logic [vbif_pkg::CSR_IDX_W-1:0]        index;
      logic [vbif_pkg::CSR_DATA_W-1:0]       data;
      bit                                    typed;
      logic signed [vbif_pkg::SAMPLE_W-1:0]  typed_out;
   } stim_row_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic signed [vbif_pkg::SAMPLE_W-1:0]   req_sample_in = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic signed [vbif_pkg::SAMPLE_W-1:0]   rsp_sample_out;
   logic                                   csr_write_en = 1'b0;
   logic [vbif_pkg::CSR_IDX_W-1:0]         csr_index = '0;
   logic [vbif_pkg::CSR_DATA_W-1:0]        csr_write_data = '0;

   // register copy and filter state of the predictor
   logic                                   cfg_enable;
   logic [vbif_pkg::COEFF_W-1:0]           cfg_hp;
   logic [vbif_pkg::COEFF_W-1:0]           cfg_lp;
   logic signed [vbif_pkg::STATE_W-1:0]    f_prev_in, f_prev_hp1, f_hp1, f_hp2, f_lp1, f_lp2;
   logic                                   f_last_en;

   logic signed [vbif_pkg::SAMPLE_W-1:0]   expected_samples[$];
   stim_row_type                           directed_rows[$];

   int   send_idle_pct = 20;
   int   recv_idle_pct = 20;
   bit   stream_phase = 0;
   bit   hold_done = 0;
   int   hold_left = 0;
   int   error_count = 0;
   int   results_checked = 0;
   int   filtered_count = 0;
   int   bypassed_count = 0;
   int   settings_count = 0;

   voice_band_iir_filter uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("voice_band_iir_filter verification failed");
      $finish;
   end

   function automatic logic signed [vbif_pkg::STATE_W-1:0] clamp32(input longint v);
      longint hi, lo;
      hi = (longint'(1) << (vbif_pkg::STATE_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi[vbif_pkg::STATE_W-1:0];
      if (v < lo) return lo[vbif_pkg::STATE_W-1:0];
      return v[vbif_pkg::STATE_W-1:0];
   endfunction

   // floor(c * v / 2^COEFF_BITS)
   function automatic longint coeff_mult(input logic [vbif_pkg::COEFF_W-1:0] c,
                                         input longint v);
      longint cl;
      cl = longint'(c);
      return (cl * v) >>> vbif_pkg::COEFF_BITS;
   endfunction

   function automatic logic signed [vbif_pkg::SAMPLE_W-1:0] filter_sample(
      input logic signed [vbif_pkg::SAMPLE_W-1:0] s);
      longint x, res;
      if (cfg_enable != f_last_en) begin
         f_prev_in = '0; f_prev_hp1 = '0; f_hp1 = '0;
         f_hp2 = '0; f_lp1 = '0; f_lp2 = '0;
         f_last_en = cfg_enable;
      end
      if (!cfg_enable) return s;
      x = longint'(s) * (longint'(1) << vbif_pkg::FRAC_BITS);
      f_hp1 = clamp32(coeff_mult(cfg_hp, longint'(f_hp1) + x - longint'(f_prev_in)));
      f_prev_in = clamp32(x);
      f_hp2 = clamp32(coeff_mult(cfg_hp,
                                 longint'(f_hp2) + longint'(f_hp1) - longint'(f_prev_hp1)));
      f_prev_hp1 = f_hp1;
      f_lp1 = clamp32(longint'(f_lp1) + coeff_mult(cfg_lp, longint'(f_hp2) - longint'(f_lp1)));
      f_lp2 = clamp32(longint'(f_lp2) + coeff_mult(cfg_lp, longint'(f_lp1) - longint'(f_lp2)));
      // double and truncate toward zero
      if (f_lp2 >= 0) res = longint'(f_lp2) >>> (vbif_pkg::FRAC_BITS - 1);
      else res = -((-longint'(f_lp2)) >>> (vbif_pkg::FRAC_BITS - 1));
      if (res > SAMPLE_MAX) res = SAMPLE_MAX;
      else if (res < SAMPLE_MIN) res = SAMPLE_MIN;
      return res[vbif_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic logic [vbif_pkg::COEFF_W-1:0] pick_coeff(
      input logic [vbif_pkg::COEFF_W-1:0] typical);
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return typical;
         default: return vbif_pkg::COEFF_W'($urandom);
      endcase
   endfunction

   task automatic add_write(input logic [vbif_pkg::CSR_IDX_W-1:0] idx,
                            input logic [vbif_pkg::CSR_DATA_W-1:0] d);
      directed_rows.push_back('{ROW_WRITE, idx, d, 1'b0, '0});
   endtask

   task automatic add_item(input logic signed [vbif_pkg::SAMPLE_W-1:0] s, input bit typed);
      directed_rows.push_back('{ROW_ITEM, vbif_pkg::CSR_ENABLE, s, typed, s});
   endtask

   // hold the input channel idle until every outstanding result is back
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [vbif_pkg::CSR_IDX_W-1:0] idx,
                            input logic [vbif_pkg::CSR_DATA_W-1:0] d);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= d;
      case (idx)
         vbif_pkg::CSR_ENABLE:   cfg_enable = d[0];
         vbif_pkg::CSR_HP_COEFF: cfg_hp = d;
         vbif_pkg::CSR_LP_COEFF: cfg_lp = d;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_sample(input logic signed [vbif_pkg::SAMPLE_W-1:0] s, input bit typed,
                              input logic signed [vbif_pkg::SAMPLE_W-1:0] typed_out);
      logic signed [vbif_pkg::SAMPLE_W-1:0] predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cfg_enable) filtered_count++;
      else bypassed_count++;
      predicted = filter_sample(s);
      expected_samples.push_back(typed ? typed_out : predicted);
      @(negedge clock);
   endtask

   // receiver: random back-pressure, plus one long hold-off when streaming starts
   always @(negedge clock) begin
      if (stream_phase && !hold_done) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_samples.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result %0d: got %0d", results_checked, rsp_sample_out);
            error_count++;
         end else begin
            logic signed [vbif_pkg::SAMPLE_W-1:0] want;
            want = expected_samples.pop_front();
            if (rsp_sample_out !== want) begin
               if (error_count < 10)
                  $display("sample mismatch at result %0d: expected %0d, got %0d",
                           results_checked, want, rsp_sample_out);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int                                    seg_len, wave_sel, period, phase, phase_items;
      logic signed [vbif_pkg::SAMPLE_W-1:0]  s;
      logic                                  en_val;

      cfg_enable = 1'b0;
      cfg_hp     = vbif_pkg::HP_COEFF_RESET;
      cfg_lp     = vbif_pkg::LP_COEFF_RESET;
      f_prev_in = '0; f_prev_hp1 = '0; f_hp1 = '0;
      f_hp2 = '0; f_lp1 = '0; f_lp2 = '0;
      f_last_en = 1'b0;

      // pass-through after reset: result equals the item
      add_item(16'sd0, 1);
      add_item(16'sh7FFF, 1);
      add_item(16'sh8000, 1);
      add_item(-16'sd1, 1);
      add_item(16'sh5555, 1);
      add_write(CSR_UNUSED, 16'hFFFF);
      add_item(16'shAAAA, 1);
      // filter with reset coefficients, full-scale steps and negative rounding
      add_write(vbif_pkg::CSR_ENABLE, 16'd1);
      add_item(16'sh7FFF, 0);
      add_item(16'sh7FFF, 0);
      add_item(16'sh8000, 0);
      add_item(16'sh8000, 0);
      add_item(-16'sd3, 0);
      // same enable again: state kept
      add_write(vbif_pkg::CSR_ENABLE, 16'd1);
      add_item(16'sd100, 0);
      add_write(vbif_pkg::CSR_HP_COEFF, 16'hFFFF);
      add_write(vbif_pkg::CSR_LP_COEFF, 16'hFFFF);
      add_item(16'sh7FFF, 0);
      add_item(16'sh8000, 0);
      add_item(16'sh7FFF, 0);
      add_item(16'sh8000, 0);
      add_write(vbif_pkg::CSR_HP_COEFF, 16'd0);
      add_write(vbif_pkg::CSR_LP_COEFF, 16'd0);
      add_item(16'sh7FFF, 0);
      add_item(-16'sd1, 0);
      // leaving the filter clears the state even in pass-through
      add_write(vbif_pkg::CSR_ENABLE, 16'd0);
      add_item(-16'sd5, 1);
      add_write(vbif_pkg::CSR_HP_COEFF, vbif_pkg::HP_COEFF_RESET);
      add_write(vbif_pkg::CSR_LP_COEFF, vbif_pkg::LP_COEFF_RESET);
      add_write(vbif_pkg::CSR_ENABLE, 16'd1);
      add_item(16'sh4000, 0);
      add_item(-16'sd1000, 0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            settle();
            write_csr(directed_rows[r].index, directed_rows[r].data);
         end else begin
            send_sample(directed_rows[r].data, directed_rows[r].typed,
                        directed_rows[r].typed_out);
         end
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 36; recv_idle_pct = 51; end
            1: begin send_idle_pct = 51; recv_idle_pct = 36; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            settle();
            en_val = ($urandom_range(99) < 85);
            write_csr(vbif_pkg::CSR_ENABLE, {15'($urandom), en_val});
            write_csr(vbif_pkg::CSR_HP_COEFF, pick_coeff(vbif_pkg::HP_COEFF_RESET));
            write_csr(vbif_pkg::CSR_LP_COEFF, pick_coeff(vbif_pkg::LP_COEFF_RESET));
            if ($urandom_range(9) == 0) write_csr(CSR_UNUSED, 16'($urandom));
            settings_count++;
            if (phase == 2) stream_phase = 1;
            seg_len  = $urandom_range(30, 90);
            wave_sel = $urandom_range(3);
            period   = $urandom_range(1, 40);
            for (int k = 0; k < seg_len; k++) begin
               case (wave_sel)
                  0: s = 16'($urandom);
                  // full-scale square wave drives the output into saturation
                  1: s = ((k / period) % 2) ? 16'sh8000 : 16'sh7FFF;
                  2: s = 16'(int'($urandom_range(600)) - 300);
                  default: begin
                     case ($urandom_range(3))
                        0: s = 16'sh7FFF;
                        1: s = 16'sh8000;
                        2: s = -16'sd1;
                        default: s = 16'($urandom);
                     endcase
                  end
               endcase
               send_sample(s, 0, '0);
            end
            phase_items += seg_len;
         end
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d filtered and %0d pass-through samples over %0d random settings,",
               filtered_count, bypassed_count, settings_count);
      $display("with %0d results checked and one long output stall.", results_checked);
      if (expected_samples.size() != 0)
         $display("%0d expected samples never arrived", expected_samples.size());
      if (error_count == 0 && expected_samples.size() == 0) begin
         $display("voice_band_iir_filter verification clean");
      end else begin
         $display("voice_band_iir_filter verification failed");
      end
      $finish;
   end

endmodule

/* voice_band_iir_filter.f */
hdl/vbif_pkg.sv
hdl/voice_band_iir_filter.sv
verif/tb.sv
